>>> design/iapi_pkg.sv
// Package: shared types, constants and command structs of the integrator.
`timescale 1ns / 1ps
`default_nettype none
package iapi_pkg;
	localparam int AxesDefault = 3;
	localparam int MaxAxes = 3;
	localparam int DivSteps = 32;

	localparam logic [29:0] AngleWrapReset = 30'd11796120;
	localparam logic [29:0] AngleDivReset = 30'd32767;
	localparam logic [29:0] DistWrapReset = 30'd208760193;
	localparam logic [29:0] DistDivReset = 30'd208760;
	localparam logic [7:0] DriftForceReset = 8'd10;
	localparam logic [14:0] DriftFloorReset = 15'd5;

	localparam logic [2:0] RegAngleWrap = 3'd0;
	localparam logic [2:0] RegAngleDiv = 3'd1;
	localparam logic [2:0] RegDistWrap = 3'd2;
	localparam logic [2:0] RegDistDiv = 3'd3;
	localparam logic [2:0] RegDriftForce = 3'd4;
	localparam logic [2:0] RegDriftFloor = 3'd5;

	// divider operand selection
	typedef enum logic [1:0] {
		DIV_DRIFT,
		DIV_ANGLE,
		DIV_POS
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME,
		ST_UPDATE,
		ST_DRIFT_START,
		ST_DRIFT_WAIT,
		ST_WRAP,
		ST_ANGLE_START,
		ST_ANGLE_WAIT,
		ST_POS_START,
		ST_POS_WAIT,
		ST_NEXT_AXIS,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic prime;
		logic update;
		logic drift_apply;
		logic wrap;
		logic div_start;
		div_sel_t div_sel;
		logic store_angle;
		logic store_pos;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic drift_needed;
	} dp_status_t;
endpackage
`default_nettype wire

>>> design/iapi_div.sv
// Serial signed divider: 32-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module iapi_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [31:0] dividend,
	input wire logic signed [31:0] divisor,
	output logic done,
	output logic signed [31:0] quotient
);
	logic busy_q;
	logic [5:0] cnt_q;
	logic [31:0] rem_q, quo_q, den_q;
	logic neg_q, zero_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(iapi_pkg::DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'(-dividend) : dividend;
			den_q <= divisor[31] ? 32'(-divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
			zero_q <= (divisor == 32'sd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) quotient = '0;
		else if (neg_q) quotient = 32'(-quo_q);
		else quotient = quo_q;
	end
endmodule
`default_nettype wire

>>> design/iapi_datapath.sv
// Datapath: per-axis state registers, adders, wrap logic and shared divider.
`timescale 1ns / 1ps
`default_nettype none
module iapi_datapath #(
	parameter int AXES = iapi_pkg::AxesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire iapi_pkg::dp_cmd_t cmd,
	output iapi_pkg::dp_status_t status,
	input wire logic [95:0] in_data,
	input wire logic [29:0] angle_wrap_limit,
	input wire logic [29:0] angle_divisor,
	input wire logic [29:0] distance_wrap_limit,
	input wire logic [29:0] distance_divisor,
	input wire logic [7:0] drift_force,
	input wire logic [14:0] drift_noise_floor,
	output logic [191:0] out_data
);
	logic signed [15:0] prev_gyro_q [iapi_pkg::MaxAxes];
	logic signed [15:0] prev_accel_q [iapi_pkg::MaxAxes];
	logic signed [31:0] rate_sum_q [iapi_pkg::MaxAxes];
	logic signed [31:0] accel_sum_q [iapi_pkg::MaxAxes];
	logic signed [31:0] vel_sum_q [iapi_pkg::MaxAxes];
	logic signed [31:0] angle_acc_q [iapi_pkg::MaxAxes];
	logic signed [31:0] pos_acc_q [iapi_pkg::MaxAxes];
	logic [15:0] turns_q [iapi_pkg::MaxAxes];
	logic [15:0] metres_q [iapi_pkg::MaxAxes];
	logic [15:0] deg_q [iapi_pkg::MaxAxes];
	logic [15:0] mm_q [iapi_pkg::MaxAxes];
	logic drift_q;

	logic [1:0] ax;
	logic signed [15:0] g, ac;
	logic signed [16:0] dg, da;
	logic signed [31:0] r_new, acs_new, vel_new, fsq;
	logic signed [17:0] fl;
	logic signed [8:0] f9;
	logic signed [31:0] div_a, div_b, div_q;
	logic signed [31:0] t_ang, t_pos;
	logic div_done;

	assign ax = cmd.axis;
	assign g = in_data[16*ax +: 16];
	assign ac = in_data[48 + 16*ax +: 16];
	assign dg = 17'(g) - 17'(prev_gyro_q[ax]);
	assign da = 17'(ac) - 17'(prev_accel_q[ax]);
	assign fl = {3'b0, drift_noise_floor};
	assign f9 = {1'b0, drift_force};
	assign fsq = 32'(drift_force) * 32'(drift_force);
	assign r_new = rate_sum_q[ax] + 32'(dg);
	assign acs_new = accel_sum_q[ax] + 32'(da);
	assign vel_new = vel_sum_q[ax] + acs_new;
	assign t_ang = angle_acc_q[ax] + rate_sum_q[ax];
	assign t_pos = pos_acc_q[ax] + vel_sum_q[ax];

	// drift pull wanted: small delta and rate sum outside +-force
	assign status.drift_needed = drift_q;
	assign status.div_done = div_done;

	always_comb begin
		case (cmd.div_sel)
			iapi_pkg::DIV_DRIFT: begin
				div_a = fsq;
				div_b = rate_sum_q[ax];
			end
			iapi_pkg::DIV_ANGLE: begin
				div_a = angle_acc_q[ax];
				div_b = {2'b0, angle_divisor};
			end
			default: begin
				div_a = pos_acc_q[ax];
				div_b = {2'b0, distance_divisor};
			end
		endcase
	end

	iapi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iapi_pkg::MaxAxes; i++) begin
				prev_gyro_q[i] <= '0;
				prev_accel_q[i] <= '0;
				rate_sum_q[i] <= '0;
				accel_sum_q[i] <= '0;
				vel_sum_q[i] <= '0;
				angle_acc_q[i] <= '0;
				pos_acc_q[i] <= '0;
				turns_q[i] <= '0;
				metres_q[i] <= '0;
				deg_q[i] <= '0;
				mm_q[i] <= '0;
			end
			drift_q <= 1'b0;
		end else begin
			if (cmd.prime) begin
				for (int i = 0; i < iapi_pkg::MaxAxes; i++) begin
					if (i < AXES) begin
						prev_gyro_q[i] <= in_data[16*i +: 16];
						prev_accel_q[i] <= in_data[48 + 16*i +: 16];
					end
				end
			end
			if (cmd.update) begin
				rate_sum_q[ax] <= r_new;
				accel_sum_q[ax] <= acs_new;
				vel_sum_q[ax] <= vel_new;
				prev_gyro_q[ax] <= g;
				prev_accel_q[ax] <= ac;
				drift_q <= (18'(dg) < fl) && (18'(dg) > -fl)
					&& ((r_new > 32'(f9)) || (r_new < -32'(f9)));
			end
			if (cmd.drift_apply) rate_sum_q[ax] <= rate_sum_q[ax] - div_q;
			if (cmd.wrap) begin
				if (t_ang >= $signed({2'b0, angle_wrap_limit})) begin
					angle_acc_q[ax] <= t_ang - $signed({2'b0, angle_wrap_limit});
					turns_q[ax] <= turns_q[ax] + 16'd1;
				end else if (t_ang < 0) begin
					angle_acc_q[ax] <= t_ang + $signed({2'b0, angle_wrap_limit});
					turns_q[ax] <= turns_q[ax] - 16'd1;
				end else angle_acc_q[ax] <= t_ang;
				if (t_pos >= $signed({2'b0, distance_wrap_limit})) begin
					pos_acc_q[ax] <= t_pos - $signed({2'b0, distance_wrap_limit});
					metres_q[ax] <= metres_q[ax] + 16'd1;
				end else if (t_pos < 0) begin
					pos_acc_q[ax] <= t_pos + $signed({2'b0, distance_wrap_limit});
					metres_q[ax] <= metres_q[ax] - 16'd1;
				end else pos_acc_q[ax] <= t_pos;
			end
			if (cmd.store_angle) deg_q[ax] <= div_q[15:0];
			if (cmd.store_pos) mm_q[ax] <= div_q[15:0];
		end
	end

	always_comb begin
		for (int i = 0; i < iapi_pkg::MaxAxes; i++) begin
			out_data[16*i +: 16] = deg_q[i];
			out_data[48 + 16*i +: 16] = turns_q[i];
			out_data[96 + 16*i +: 16] = mm_q[i];
			out_data[144 + 16*i +: 16] = metres_q[i];
		end
	end
endmodule
`default_nettype wire

>>> design/iapi_ctrl.sv
// Controller: sequences the per-axis update, drift pull, wrap and divisions.
`timescale 1ns / 1ps
`default_nettype none
module iapi_ctrl #(
	parameter int AXES = iapi_pkg::AxesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_free,
	input wire iapi_pkg::dp_status_t status,
	output iapi_pkg::dp_cmd_t cmd,
	output logic busy,
	output logic result_load
);
	iapi_pkg::state_t state_q, state_d;
	logic first_q, first_d;
	logic [1:0] axis_q, axis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iapi_pkg::ST_IDLE;
			first_q <= 1'b1;
			axis_q <= '0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			axis_q <= axis_d;
		end
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		axis_d = axis_q;
		cmd = '0;
		cmd.axis = axis_q;
		cmd.div_sel = iapi_pkg::DIV_DRIFT;
		result_load = 1'b0;
		busy = (state_q != iapi_pkg::ST_IDLE);
		case (state_q)
			iapi_pkg::ST_IDLE: begin
				if (in_fire) begin
					axis_d = '0;
					state_d = first_q ? iapi_pkg::ST_PRIME : iapi_pkg::ST_UPDATE;
				end
			end
			iapi_pkg::ST_PRIME: begin
				cmd.prime = 1'b1;
				first_d = 1'b0;
				state_d = iapi_pkg::ST_IDLE;
			end
			iapi_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = iapi_pkg::ST_DRIFT_START;
			end
			iapi_pkg::ST_DRIFT_START: begin
				if (status.drift_needed) begin
					cmd.div_start = 1'b1;
					state_d = iapi_pkg::ST_DRIFT_WAIT;
				end else state_d = iapi_pkg::ST_WRAP;
			end
			iapi_pkg::ST_DRIFT_WAIT: begin
				if (status.div_done) begin
					cmd.drift_apply = 1'b1;
					state_d = iapi_pkg::ST_WRAP;
				end
			end
			iapi_pkg::ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d = iapi_pkg::ST_ANGLE_START;
			end
			iapi_pkg::ST_ANGLE_START: begin
				cmd.div_sel = iapi_pkg::DIV_ANGLE;
				cmd.div_start = 1'b1;
				state_d = iapi_pkg::ST_ANGLE_WAIT;
			end
			iapi_pkg::ST_ANGLE_WAIT: begin
				if (status.div_done) begin
					cmd.store_angle = 1'b1;
					state_d = iapi_pkg::ST_POS_START;
				end
			end
			iapi_pkg::ST_POS_START: begin
				cmd.div_sel = iapi_pkg::DIV_POS;
				cmd.div_start = 1'b1;
				state_d = iapi_pkg::ST_POS_WAIT;
			end
			iapi_pkg::ST_POS_WAIT: begin
				if (status.div_done) begin
					cmd.store_pos = 1'b1;
					state_d = iapi_pkg::ST_NEXT_AXIS;
				end
			end
			iapi_pkg::ST_NEXT_AXIS: begin
				if (32'(axis_q) == AXES - 1) state_d = iapi_pkg::ST_OUTPUT;
				else begin
					axis_d = axis_q + 2'd1;
					state_d = iapi_pkg::ST_UPDATE;
				end
			end
			iapi_pkg::ST_OUTPUT: begin
				if (out_free) begin
					result_load = 1'b1;
					state_d = iapi_pkg::ST_IDLE;
				end
			end
			default: state_d = iapi_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> design/inertial_angle_position_integrator.sv
// Top level: stream ports, configuration registers, output register.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: gyro x,y,z, accel x,y,z (16 b each)
// m_axis    out  m_axis_tvalid/tready      tdata: deg x..z, turns x..z, mm x..z, m x..z
// cfg       in   cfg_valid/cfg_ready       cfg_index (3 b), cfg_data (30 b)
//
// Per axis: update, a drift division on the shared serial divider if the drift
// pull fires, wrap, then an angle and a position division on the same divider.
// The priming item only stores the previous samples and yields no result.
// Reset: all sums zero, registers at defaults, first item primes only.
// Stalls: the result waits in the output register; the next item is taken
// once the block is idle, and a full output register holds the next result back.
`timescale 1ns / 1ps
`default_nettype none
module inertial_angle_position_integrator #(
	parameter int AXES = iapi_pkg::AxesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
	input wire logic [95:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// angle_deg_x/y/z, angle_turns_x/y/z, pos_mm_x/y/z, pos_m_x/y/z
	output logic [191:0] m_axis_tdata,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [29:0] cfg_data
);
	logic [29:0] angle_wrap_q, angle_div_q, dist_wrap_q, dist_div_q;
	logic [7:0] force_q;
	logic [14:0] floor_q;
	logic [95:0] in_q;
	logic [191:0] res;
	logic busy, result_load, in_fire;
	iapi_pkg::dp_cmd_t cmd;
	iapi_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_wrap_q <= iapi_pkg::AngleWrapReset;
			angle_div_q <= iapi_pkg::AngleDivReset;
			dist_wrap_q <= iapi_pkg::DistWrapReset;
			dist_div_q <= iapi_pkg::DistDivReset;
			force_q <= iapi_pkg::DriftForceReset;
			floor_q <= iapi_pkg::DriftFloorReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				iapi_pkg::RegAngleWrap: angle_wrap_q <= cfg_data;
				iapi_pkg::RegAngleDiv: angle_div_q <= cfg_data;
				iapi_pkg::RegDistWrap: dist_wrap_q <= cfg_data;
				iapi_pkg::RegDistDiv: dist_div_q <= cfg_data;
				iapi_pkg::RegDriftForce: force_q <= cfg_data[7:0];
				iapi_pkg::RegDriftFloor: floor_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// input item held for the whole computation
	always_ff @(posedge clk) begin
		if (in_fire) in_q <= s_axis_tdata;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (result_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (result_load) m_axis_tdata <= res;
	end

	iapi_ctrl #(.AXES(AXES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_free(!m_axis_tvalid || m_axis_tready), .status(status),
		.cmd(cmd), .busy(busy), .result_load(result_load)
	);

	iapi_datapath #(.AXES(AXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .in_data(in_q),
		.angle_wrap_limit(angle_wrap_q), .angle_divisor(angle_div_q),
		.distance_wrap_limit(dist_wrap_q), .distance_divisor(dist_div_q),
		.drift_force(force_q), .drift_noise_floor(floor_q), .out_data(res)
	);

`ifndef ASSERT_OFF
	// no item is taken while a computation runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("item accepted while busy");
	// a result is only loaded while the output register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten");
	// divider start never coincides with a result load
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_start && result_load)) else $error("start during load");
`endif
endmodule
`default_nettype wire
